[rtl/qau_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, opcodes, stage-to-stage types and the clipping function.
// ----------------------------------------------------------------------------
package qau_pkg;

    // Component format: signed Q4.12.
    localparam int COMP_W = 16;
    localparam int FRAC   = 12;
    localparam int FUNC_W = 3;

    // Derived widths.
    localparam int PROD_W = 2 * COMP_W;      // full signed product
    localparam int SUM_W  = PROD_W + 2;      // sum of four products
    localparam int SQ_W   = 2 * COMP_W - 1;  // magnitude of one square
    localparam int NORM_W = SQ_W + 2;        // sum of four squares
    localparam int LIN_W  = COMP_W + 1;      // sum or difference of two components

    // Opcodes.
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MUL   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SCALE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CONJ  = 3'd4;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [LIN_W-1:0]  t_lin;
    typedef logic        [SQ_W-1:0]   t_sq;
    typedef logic        [NORM_W-1:0] t_norm;

    // One input item as registered at the block boundary.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        t_comp [3:0]       a;
        t_comp [3:0]       b;
        t_comp             f;
    } t_item;

    // Products, squares and linear terms handed from the multiply stage.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        t_prod [3:0][3:0]  prod;   // prod[r][c] = a[r] * operand[c]
        t_sq   [3:0]       sq_a;
        t_sq   [3:0]       sq_b;
        t_lin  [3:0]       lin;
        logic              eq;
    } t_mid;

    // One result item.
    typedef struct packed {
        t_comp [3:0] r;
        t_norm       norm_sq;
        logic        norm_greater;
        logic        norm_less;
        logic        all_equal;
        logic        saturated;
    } t_res;

    // A component value with its clipping flag.
    typedef struct packed {
        logic  sat;
        t_comp val;
    } t_sat;

    // Clip a wide signed value to the component range.
    function automatic t_sat sat_comp(input t_sum x);
        t_sat o;
        t_sum cmax;
        t_sum cmin;
        cmax = SUM_W'($signed({1'b0, {(COMP_W-1){1'b1}}}));
        cmin = SUM_W'($signed({1'b1, {(COMP_W-1){1'b0}}}));
        if (x > cmax) begin
            o.sat = 1'b1;
            o.val = {1'b0, {(COMP_W-1){1'b1}}};
        end else if (x < cmin) begin
            o.sat = 1'b1;
            o.val = {1'b1, {(COMP_W-1){1'b0}}};
        end else begin
            o.sat = 1'b0;
            o.val = x[COMP_W-1:0];
        end
        return o;
    endfunction

endpackage

[rtl/qau_mul_stage.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit: multiply stage
// Forms all cross products, the squares for both norms, the linear terms for
// add, subtract and conjugate, and the equality flag, then registers them.
// ----------------------------------------------------------------------------
module qau_mul_stage
    import qau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_mid  o_mid
);

    logic r_valid;
    t_mid r_mid;
    t_mid n_mid;
    t_comp [3:0] op;
    t_prod sq_a_full;
    t_prod sq_b_full;

    // Scale reuses the diagonal products with the factor in place of B.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            op[c] = (i_item.func == FN_SCALE) ? i_item.f : i_item.b[c];
        end
    end

    always_comb begin
        n_mid      = '0;
        sq_a_full  = '0;
        sq_b_full  = '0;
        n_mid.func = i_item.func;
        n_mid.eq   = (i_item.a == i_item.b);

        // Cross products and squares.
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_mid.prod[r][c] = PROD_W'($signed(i_item.a[r]))
                                 * PROD_W'($signed(op[c]));
            end
            sq_a_full = PROD_W'($signed(i_item.a[r])) * PROD_W'($signed(i_item.a[r]));
            sq_b_full = PROD_W'($signed(i_item.b[r])) * PROD_W'($signed(i_item.b[r]));
            n_mid.sq_a[r] = sq_a_full[SQ_W-1:0];
            n_mid.sq_b[r] = sq_b_full[SQ_W-1:0];
        end

        // Linear terms, clipped in the next stage.
        for (int i = 0; i < 4; i++) begin
            case (i_item.func)
                FN_ADD:  n_mid.lin[i] = LIN_W'($signed(i_item.a[i]))
                                      + LIN_W'($signed(i_item.b[i]));
                FN_SUB:  n_mid.lin[i] = LIN_W'($signed(i_item.a[i]))
                                      - LIN_W'($signed(i_item.b[i]));
                FN_CONJ: n_mid.lin[i] = (i == 0) ? LIN_W'($signed(i_item.a[i]))
                                                 : -LIN_W'($signed(i_item.a[i]));
                default: n_mid.lin[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

    assign o_valid = r_valid;
    assign o_mid   = r_mid;

endmodule

[rtl/qau_fin_stage.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit: finish stage
// Sums the products, shifts and clips the components, adds up both norms and
// compares them, and registers the result item.
// ----------------------------------------------------------------------------
module qau_fin_stage
    import qau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_mid i_mid,
    output logic o_valid,
    output t_res o_res
);

    logic r_valid;
    t_res r_res;
    t_res n_res;
    t_sum [3:0] hsum;
    t_sat [3:0] cl;
    t_norm norm_a;
    t_norm norm_b;

    function automatic t_sum ext(input t_prod p);
        return SUM_W'(p);
    endfunction

    // Hamilton product sums, one per component.
    always_comb begin
        hsum[0] = ext(i_mid.prod[0][0]) - ext(i_mid.prod[1][1])
                - ext(i_mid.prod[2][2]) - ext(i_mid.prod[3][3]);
        hsum[1] = ext(i_mid.prod[0][1]) + ext(i_mid.prod[1][0])
                + ext(i_mid.prod[2][3]) - ext(i_mid.prod[3][2]);
        hsum[2] = ext(i_mid.prod[0][2]) - ext(i_mid.prod[1][3])
                + ext(i_mid.prod[2][0]) + ext(i_mid.prod[3][1]);
        hsum[3] = ext(i_mid.prod[0][3]) + ext(i_mid.prod[1][2])
                - ext(i_mid.prod[2][1]) + ext(i_mid.prod[3][0]);
    end

    // Component selection and clipping; the shift rounds toward minus infinity.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            case (i_mid.func) inside
                FN_ADD, FN_SUB, FN_CONJ: cl[i] = sat_comp(SUM_W'(i_mid.lin[i]));
                FN_MUL:   cl[i] = sat_comp(hsum[i] >>> FRAC);
                FN_SCALE: cl[i] = sat_comp(ext(i_mid.prod[i][i]) >>> FRAC);
                default:  cl[i] = '0;
            endcase
        end
    end

    // Norms of both quaternions and their comparison.
    always_comb begin
        norm_a = NORM_W'(i_mid.sq_a[0]) + NORM_W'(i_mid.sq_a[1])
               + NORM_W'(i_mid.sq_a[2]) + NORM_W'(i_mid.sq_a[3]);
        norm_b = NORM_W'(i_mid.sq_b[0]) + NORM_W'(i_mid.sq_b[1])
               + NORM_W'(i_mid.sq_b[2]) + NORM_W'(i_mid.sq_b[3]);
        for (int i = 0; i < 4; i++) begin
            n_res.r[i] = cl[i].val;
        end
        n_res.norm_sq      = norm_a;
        n_res.norm_greater = (norm_a > norm_b);
        n_res.norm_less    = (norm_a < norm_b);
        n_res.all_equal    = i_mid.eq;
        n_res.saturated    = cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/quaternion_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Add, subtract, Hamilton product, scale and conjugate on Q4.12 quaternions,
// with the squared norm of A, norm comparison, equality and clip flags.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle and busy is always low. Each
// item gives exactly one result, shown for a single cycle on o_valid after
// the item has passed the registers below, one after the other, in order.
// The three registers are an input register, a product register after the
// sixteen multipliers and the squarers, and a result register after the sums,
// clipping and norm compare. Results cannot be held off, so the receiver must
// take every o_valid cycle. Opcodes five to seven give a zero quaternion with
// the norm and flags still computed.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
    import qau_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [COMP_W-1:0] i_a_scalar,
    input  logic signed [COMP_W-1:0] i_a_i,
    input  logic signed [COMP_W-1:0] i_a_j,
    input  logic signed [COMP_W-1:0] i_a_k,
    input  logic signed [COMP_W-1:0] i_b_scalar,
    input  logic signed [COMP_W-1:0] i_b_i,
    input  logic signed [COMP_W-1:0] i_b_j,
    input  logic signed [COMP_W-1:0] i_b_k,
    input  logic signed [COMP_W-1:0] i_scale_factor,
    output logic                     o_valid,
    output logic signed [COMP_W-1:0] o_r_scalar,
    output logic signed [COMP_W-1:0] o_r_i,
    output logic signed [COMP_W-1:0] o_r_j,
    output logic signed [COMP_W-1:0] o_r_k,
    output logic [NORM_W-1:0]        o_norm_sq,
    output logic                     o_norm_greater,
    output logic                     o_norm_less,
    output logic                     o_all_equal,
    output logic                     o_saturated
);

    logic  r_in_valid;
    t_item r_item;
    t_item n_item;
    logic  mid_valid;
    t_mid  mid;
    t_res  res;

    // Every stage advances each cycle, so the unit is never busy.
    assign busy = 1'b0;

    // Input register.
    always_comb begin
        n_item.func = i_func;
        n_item.a[0] = i_a_scalar;
        n_item.a[1] = i_a_i;
        n_item.a[2] = i_a_j;
        n_item.a[3] = i_a_k;
        n_item.b[0] = i_b_scalar;
        n_item.b[1] = i_b_i;
        n_item.b[2] = i_b_j;
        n_item.b[3] = i_b_k;
        n_item.f    = i_scale_factor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    qau_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_item),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    qau_fin_stage u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .o_valid (o_valid),
        .o_res   (res)
    );

    // Result ports.
    assign o_r_scalar     = res.r[0];
    assign o_r_i          = res.r[1];
    assign o_r_j          = res.r[2];
    assign o_r_k          = res.r[3];
    assign o_norm_sq      = res.norm_sq;
    assign o_norm_greater = res.norm_greater;
    assign o_norm_less    = res.norm_less;
    assign o_all_equal    = res.all_equal;
    assign o_saturated    = res.saturated;

endmodule
